@@ hdl/clpc_pkg.sv @@
// Shared types and helpers for the color lookup pixel classifier.
// Holds the input and output word structs, operation codes and table addressing.
// No dependencies.
package clpc_pkg;

    localparam int unsigned MIN_SHIFT  = 3;
    localparam int unsigned MAX_SHIFT  = 8;
    localparam int unsigned ADDR_W     = 15;
    localparam int unsigned TABLE_SIZE = 32768;
    localparam int unsigned COORD_W    = 11;

    localparam logic [1:0] OP_CLASSIFY = 2'd0;
    localparam logic [1:0] OP_CLEAR    = 2'd1;
    localparam logic [1:0] OP_FILL     = 2'd2;

    localparam logic [1:0] REG_SHIFT_FIRST  = 2'd0;
    localparam logic [1:0] REG_SHIFT_SECOND = 2'd1;
    localparam logic [1:0] REG_SHIFT_THIRD  = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] chan_first;
        logic [7:0] chan_second;
        logic [7:0] chan_third;
        logic [7:0] radius_first;
        logic [7:0] radius_second;
        logic [7:0] radius_third;
        logic [7:0] fill_value;
    } t_in_word;

    typedef struct packed {
        logic [7:0] label;
        logic       is_classification;
    } t_out_word;

    // Clamp a shift register to the legal range.
    function automatic logic [3:0] eff_shift(input logic [3:0] s);
        logic [3:0] r;
        r = s;
        if (s < 4'(MIN_SHIFT)) r = 4'(MIN_SHIFT);
        if (s > 4'(MAX_SHIFT)) r = 4'(MAX_SHIFT);
        return r;
    endfunction

    // Cells per axis are powers of two, so the address is a packing of indices.
    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [7:0] x,
        input logic [7:0] y,
        input logic [7:0] z,
        input logic [3:0] s0,
        input logic [3:0] s1,
        input logic [3:0] s2
    );
        logic [7:0] i0;
        logic [7:0] i1;
        logic [7:0] i2;
        logic [4:0] sh1;
        logic [4:0] sh2;
        i0  = x >> s0;
        i1  = y >> s1;
        i2  = z >> s2;
        sh1 = 5'd8 - 5'(s0);
        sh2 = 5'd16 - 5'(s0) - 5'(s1);
        return ADDR_W'(i0) | (ADDR_W'(i1) << sh1) | (ADDR_W'(i2) << sh2);
    endfunction

    function automatic logic signed [COORD_W-1:0] box_lo(
        input logic [7:0] c,
        input logic [7:0] r
    );
        return $signed({3'b000, c}) - $signed({3'b000, r});
    endfunction

    function automatic logic signed [COORD_W-1:0] box_hi(
        input logic [7:0] c,
        input logic [7:0] r
    );
        return $signed({3'b000, c}) + $signed({3'b000, r});
    endfunction

endpackage

@@ hdl/color_lut_pixel_classifier_core.sv @@
// Top level of the color lookup pixel classifier: sequencer, shift registers,
// output register. Depends on clpc_pkg and clpc_table.
//
// Usage:
//   Input words arrive on i_in_valid / i_in_word and are taken when o_in_stall
//   is low. Results leave on o_out_valid / o_out_word and are taken when
//   i_out_stall is low. Every input word gives exactly one output word.
//   Shift registers are written through i_cfg_we / i_cfg_index / i_cfg_data;
//   the user must write them only while the block is idle; it is not enforced.
// Timing:
//   One word is worked at a time; o_in_stall stays high until its result has
//   been loaded into the output register. Classify: the word passes the read
//   state, which waits out the registered read of the label table, and then
//   the response state. Clear: one entry written per cycle over the extent.
//   Box fill: a walk step writes one point, or skips a point, row or plane
//   that lies outside 0..255, or moves on to the next row or plane.
// Reset and stall:
//   Reset returns the sequencer to idle, empties the output register and sets
//   all shifts to 3. The table is not cleared; software clears or fills it
//   before classifying. While the receiver stalls, the output word holds, and
//   a following input word may still be accepted and worked; its result waits
//   until the output register frees.
module color_lut_pixel_classifier_core
    import clpc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [3:0] i_cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_CLEAR = 3'd2;
    localparam logic [2:0] ST_FILL  = 3'd3;
    localparam logic [2:0] ST_RESP  = 3'd4;

    logic [2:0] r_state, n_state;
    logic [3:0] r_shift0, r_shift1, r_shift2;
    logic       r_out_valid, n_out_valid;
    t_out_word  r_out_word, n_out_word;
    t_in_word   r_item, n_item;
    logic [ADDR_W-1:0] r_count, n_count;
    logic signed [COORD_W-1:0] r_p, n_p, r_q, n_q, r_r, n_r;

    logic [3:0] s0, s1, s2;
    logic [4:0] clr_exp;
    logic [ADDR_W-1:0] clr_last;
    logic signed [COORD_W-1:0] lo1, lo2, hi0, hi1, hi2;
    logic signed [COORD_W-1:0] step0, step1, step2;
    logic p_ok, q_ok, r_ok;
    logic out_free;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [7:0]        mem_rd_data;

    assign s0 = eff_shift(r_shift0);
    assign s1 = eff_shift(r_shift1);
    assign s2 = eff_shift(r_shift2);

    // clear extent is 2^(24 - s0 - s1 - s2) entries
    assign clr_exp  = 5'd24 - 5'(s0) - 5'(s1) - 5'(s2);
    assign clr_last = ADDR_W'((16'd1 << clr_exp) - 16'd1);

    assign lo1 = box_lo(r_item.chan_second, r_item.radius_second);
    assign lo2 = box_lo(r_item.chan_third, r_item.radius_third);
    assign hi0 = box_hi(r_item.chan_first, r_item.radius_first);
    assign hi1 = box_hi(r_item.chan_second, r_item.radius_second);
    assign hi2 = box_hi(r_item.chan_third, r_item.radius_third);

    assign step0 = COORD_W'(1) << s0;
    assign step1 = COORD_W'(1) << s1;
    assign step2 = COORD_W'(1) << s2;

    // in 0..255 exactly when the upper bits (sign included) are zero
    assign p_ok = (r_p[COORD_W-1:8] == '0);
    assign q_ok = (r_q[COORD_W-1:8] == '0);
    assign r_ok = (r_r[COORD_W-1:8] == '0);

    assign out_free = !r_out_valid || !i_out_stall;

    assign mem_rd_addr = cell_addr(r_item.chan_first, r_item.chan_second,
                                   r_item.chan_third, s0, s1, s2);

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_count     = r_count;
        n_p         = r_p;
        n_q         = r_q;
        n_r         = r_r;
        n_out_word  = r_out_word;
        n_out_valid = r_out_valid && i_out_stall;
        mem_we      = 1'b0;
        mem_wr_addr = cell_addr(r_p[7:0], r_q[7:0], r_r[7:0], s0, s1, s2);

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_word;
                    n_count = '0;
                    n_p     = box_lo(i_in_word.chan_first, i_in_word.radius_first);
                    n_q     = box_lo(i_in_word.chan_second, i_in_word.radius_second);
                    n_r     = box_lo(i_in_word.chan_third, i_in_word.radius_third);
                    case (i_in_word.operation)
                        OP_CLASSIFY: n_state = ST_READ;
                        OP_CLEAR:    n_state = ST_CLEAR;
                        OP_FILL:     n_state = ST_FILL;
                        default:     n_state = ST_RESP;
                    endcase
                end
            end
            ST_READ: begin
                n_state = ST_RESP;
            end
            ST_CLEAR: begin
                mem_we      = 1'b1;
                mem_wr_addr = r_count;
                if (r_count == clr_last) begin
                    n_state = ST_RESP;
                end else begin
                    n_count = r_count + ADDR_W'(1);
                end
            end
            ST_FILL: begin
                if (r_p > hi0) begin
                    n_state = ST_RESP;
                end else if (!p_ok || r_q > hi1) begin
                    // next plane
                    n_p = r_p + step0;
                    n_q = lo1;
                    n_r = lo2;
                end else if (!q_ok || r_r > hi2) begin
                    // next row
                    n_q = r_q + step1;
                    n_r = lo2;
                end else begin
                    mem_we = r_ok;
                    n_r    = r_r + step2;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_item.operation == OP_CLASSIFY) begin
                        n_out_word.label             = mem_rd_data;
                        n_out_word.is_classification = 1'b1;
                    end else begin
                        n_out_word.label             = 8'd0;
                        n_out_word.is_classification = 1'b0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_shift0    <= 4'd3;
            r_shift1    <= 4'd3;
            r_shift2    <= 4'd3;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_SHIFT_FIRST:  r_shift0 <= i_cfg_data;
                    REG_SHIFT_SECOND: r_shift1 <= i_cfg_data;
                    REG_SHIFT_THIRD:  r_shift2 <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_count    <= n_count;
        r_p        <= n_p;
        r_q        <= n_q;
        r_r        <= n_r;
        r_out_word <= n_out_word;
    end

    clpc_table u_table (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (r_item.fill_value),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ hdl/clpc_table.sv @@
// Label table storage: single write port, one registered read port.
// Depends on clpc_pkg for the address width and depth.
module clpc_table
    import clpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);

    logic [7:0] r_mem [TABLE_SIZE];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
